FILE: hdl/source_text_tokenizer_core_defines.svh
// Assertion macros shared by the tokenizer modules.
// Each expects signals named clock and reset in the using module.
`ifndef SOURCE_TEXT_TOKENIZER_CORE_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/stt_pkg.sv
package stt_pkg;

   localparam int POSITION_BITS = 16;
   localparam int FIELD_BITS    = 16;
   localparam int RSP_DEPTH     = 4;

   typedef enum logic [3:0] {
      KIND_EOF,
      KIND_IDENT,
      KIND_INT,
      KIND_LPAREN,
      KIND_RPAREN,
      KIND_LBRACK,
      KIND_RBRACK,
      KIND_COMMA,
      KIND_COLON,
      KIND_EQUAL,
      KIND_MINUS,
      KIND_ARROW,
      KIND_INVALID
   } token_kind_type;

   typedef struct packed {
      token_kind_type          kind;
      logic [FIELD_BITS-1:0]   start_offset;
      logic [FIELD_BITS-1:0]   token_length;
      logic [FIELD_BITS-1:0]   start_line;
      logic [FIELD_BITS-1:0]   start_column;
      logic                    last_of_run;
   } token_type;

   // Up to two tokens per item, already in output order.
   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } token_push_type;

endpackage

FILE: hdl/stt_scan.sv
`include "source_text_tokenizer_core_defines.svh"

module stt_scan #(
   parameter int POSITION_BITS = stt_pkg::POSITION_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_char_byte,
   input  logic                   req_end_of_source,
   input  logic                   room,
   output stt_pkg::token_push_type push
);

   localparam int FB       = stt_pkg::FIELD_BITS;
   localparam int EXT_BITS = (POSITION_BITS > FB) ? POSITION_BITS : FB;
   localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
   localparam logic [POSITION_BITS-1:0] POS_ONE   = POSITION_BITS'(1);
   localparam logic [FB-1:0]            FIELD_MAX = '1;

   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_HASH   = 8'h23;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_COLON  = 8'h3A;
   localparam logic [7:0] CHAR_EQUAL  = 8'h3D;
   localparam logic [7:0] CHAR_GT     = 8'h3E;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LBRACK = 8'h5B;
   localparam logic [7:0] CHAR_RBRACK = 8'h5D;
   localparam logic [7:0] CHAR_UNDER  = 8'h5F;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_COMMENT,
      MODE_IDENT,
      MODE_INT,
      MODE_MINUS
   } mode_type;

   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               char_ff;
   logic                     end_ff;
   mode_type                 mode_ff, mode_in;
   logic [POSITION_BITS-1:0] off_ff, off_in, line_ff, line_in, col_ff, col_in;
   logic [POSITION_BITS-1:0] p_off_ff, p_off_in, p_line_ff, p_line_in, p_col_ff, p_col_in;
   logic [POSITION_BITS-1:0] off_c, line_c, col_c;
   logic                     req_accept, fire;
   logic                     flush_v, a_v, b_v;
   stt_pkg::token_type       flush_tok, a_tok, b_tok;

   function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
      return (v == POS_MAX) ? v : v + POS_ONE;
   endfunction

   function automatic logic [FB-1:0] clamp(input logic [POSITION_BITS-1:0] v);
      logic [EXT_BITS-1:0] ext;
      ext = EXT_BITS'(v);
      return (ext > EXT_BITS'(FIELD_MAX)) ? FIELD_MAX : ext[FB-1:0];
   endfunction

   function automatic logic is_letter(input logic [7:0] b);
      return (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) ||
             (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= CHAR_ZERO && b <= CHAR_NINE;
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR);
   endfunction

   function automatic stt_pkg::token_kind_type single_kind(input logic [7:0] b);
      stt_pkg::token_kind_type k;
      unique case (b)
         CHAR_LPAREN: k = stt_pkg::KIND_LPAREN;
         CHAR_RPAREN: k = stt_pkg::KIND_RPAREN;
         CHAR_LBRACK: k = stt_pkg::KIND_LBRACK;
         CHAR_RBRACK: k = stt_pkg::KIND_RBRACK;
         CHAR_COMMA:  k = stt_pkg::KIND_COMMA;
         CHAR_COLON:  k = stt_pkg::KIND_COLON;
         CHAR_EQUAL:  k = stt_pkg::KIND_EQUAL;
         default:     k = stt_pkg::KIND_INVALID;
      endcase
      return k;
   endfunction

   function automatic stt_pkg::token_type make_tok(
      input stt_pkg::token_kind_type  kind,
      input logic [POSITION_BITS-1:0] off,
      input logic [FB-1:0]            len,
      input logic [POSITION_BITS-1:0] line,
      input logic [POSITION_BITS-1:0] col
   );
      stt_pkg::token_type t;
      t.kind         = kind;
      t.start_offset = clamp(off);
      t.token_length = len;
      t.start_line   = clamp(line);
      t.start_column = clamp(col);
      t.last_of_run  = 1'b0;
      return t;
   endfunction

   assign req_accept  = req_valid && req_ready;
   assign fire        = in_valid_ff && room;
   assign req_ready   = !in_valid_ff || fire;
   assign in_valid_in = req_accept || (in_valid_ff && !fire);

   // position after taking the held byte
   always_comb begin
      off_c = sat_inc(off_ff);
      if (char_ff == CHAR_LF) begin
         line_c = sat_inc(line_ff);
         col_c  = POS_ONE;
      end else begin
         line_c = line_ff;
         col_c  = sat_inc(col_ff);
      end
   end

   always_comb begin
      flush_v   = 1'b1;
      flush_tok = make_tok(stt_pkg::KIND_MINUS, p_off_ff, FB'(1), p_line_ff, p_col_ff);
      unique case (mode_ff)
         MODE_IDENT: flush_tok = make_tok(stt_pkg::KIND_IDENT, p_off_ff,
                                          clamp(off_ff - p_off_ff), p_line_ff, p_col_ff);
         MODE_INT:   flush_tok = make_tok(stt_pkg::KIND_INT, p_off_ff,
                                          clamp(off_ff - p_off_ff), p_line_ff, p_col_ff);
         MODE_MINUS: flush_v   = 1'b1;
         default:    flush_v   = 1'b0;
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      off_in    = off_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      p_off_in  = p_off_ff;
      p_line_in = p_line_ff;
      p_col_in  = p_col_ff;
      a_v       = 1'b0;
      a_tok     = flush_tok;
      b_v       = 1'b0;
      b_tok     = make_tok(single_kind(char_ff), off_ff, FB'(1), line_ff, col_ff);
      if (fire) begin
         if (end_ff) begin
            a_v       = flush_v;
            b_v       = 1'b1;
            b_tok     = make_tok(stt_pkg::KIND_EOF, off_ff, '0, line_ff, col_ff);
            mode_in   = MODE_IDLE;
            off_in    = '0;
            line_in   = POS_ONE;
            col_in    = POS_ONE;
            p_off_in  = '0;
            p_line_in = POS_ONE;
            p_col_in  = POS_ONE;
         end else begin
            off_in  = off_c;
            line_in = line_c;
            col_in  = col_c;
            priority if (mode_ff == MODE_COMMENT) begin
               if (char_ff == CHAR_LF) begin
                  mode_in = MODE_IDLE;
               end
            end else if (mode_ff == MODE_IDENT &&
                         (char_ff == CHAR_UNDER || is_letter(char_ff) || is_digit(char_ff))) begin
               mode_in = MODE_IDENT;
            end else if (mode_ff == MODE_INT && is_digit(char_ff)) begin
               mode_in = MODE_INT;
            end else if (mode_ff == MODE_MINUS && char_ff == CHAR_GT) begin
               a_v     = 1'b1;
               a_tok   = make_tok(stt_pkg::KIND_ARROW, p_off_ff, FB'(2), p_line_ff, p_col_ff);
               mode_in = MODE_IDLE;
            end else begin
               a_v     = flush_v;
               mode_in = MODE_IDLE;
               priority if (is_space(char_ff)) begin
                  mode_in = MODE_IDLE;
               end else if (char_ff == CHAR_HASH) begin
                  mode_in = MODE_COMMENT;
               end else if (char_ff == CHAR_UNDER || is_letter(char_ff) ||
                            is_digit(char_ff) || char_ff == CHAR_MINUS) begin
                  if (is_digit(char_ff)) begin
                     mode_in = MODE_INT;
                  end else if (char_ff == CHAR_MINUS) begin
                     mode_in = MODE_MINUS;
                  end else begin
                     mode_in = MODE_IDENT;
                  end
                  p_off_in  = off_ff;
                  p_line_in = line_ff;
                  p_col_in  = col_ff;
               end else begin
                  b_v = 1'b1;
               end
            end
         end
      end
   end

   // pack tokens in order; last one of the item carries the marker
   always_comb begin
      push.count              = {1'b0, a_v} + {1'b0, b_v};
      push.first              = a_v ? a_tok : b_tok;
      push.first.last_of_run  = !(a_v && b_v);
      push.second             = b_tok;
      push.second.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         off_ff      <= '0;
         line_ff     <= POS_ONE;
         col_ff      <= POS_ONE;
         p_off_ff    <= '0;
         p_line_ff   <= POS_ONE;
         p_col_ff    <= POS_ONE;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         off_ff      <= off_in;
         line_ff     <= line_in;
         col_ff      <= col_in;
         p_off_ff    <= p_off_in;
         p_line_ff   <= p_line_in;
         p_col_ff    <= p_col_in;
      end
      if (req_accept) begin
         char_ff <= req_char_byte;
         end_ff  <= req_end_of_source;
      end
   end

   `STT_ASSERT_SAME(a_push_needs_fire, push.count != 2'd0, fire, "tokens pushed without an item")
   `STT_ASSERT_NEXT(a_end_resets, fire && end_ff, mode_ff == MODE_IDLE && off_ff == '0, "end did not reset")
   `STT_ASSERT_SAME(a_two_needs_first, push.count == 2'd2, a_v && b_v, "two tokens from one source")

endmodule

FILE: hdl/stt_rsp_fifo.sv
`include "source_text_tokenizer_core_defines.svh"

module stt_rsp_fifo #(
   parameter int DEPTH = stt_pkg::RSP_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  stt_pkg::token_push_type push,
   output logic                    room,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output stt_pkg::token_type      rsp_token
);

   localparam int PTR_BITS   = $clog2(DEPTH);
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   stt_pkg::token_type      entry_ff [DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_ptr_next;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    pop;

   assign pop         = rsp_valid && rsp_ready;
   assign rsp_valid   = count_ff != '0;
   assign rsp_token   = entry_ff[rd_ptr_ff];
   assign room        = count_ff <= COUNT_BITS'(DEPTH - 2);
   assign wr_ptr_next = wr_ptr_ff + PTR_BITS'(1);
   assign wr_ptr_in   = wr_ptr_ff + PTR_BITS'(push.count);
   assign rd_ptr_in   = rd_ptr_ff + PTR_BITS'(pop);
   assign count_in    = count_ff + COUNT_BITS'(push.count) - COUNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

   `STT_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= COUNT_BITS'(DEPTH), "queue overfilled")
   `STT_ASSERT_SAME(a_push_has_room, push.count != 2'd0, room, "push without room")
   `STT_ASSERT_NEXT(a_pop_drains, pop && push.count == 2'd0, count_ff == $past(count_ff) - COUNT_BITS'(1), "pop lost")

endmodule

FILE: hdl/source_text_tokenizer_core.sv
// Streaming tokenizer: one source byte (or the end marker) per input item, tokens out
// with kind, start offset, length, line and column, last_of_run on the final token of
// each item. An item is registered at acceptance, scanned once the result queue has
// room, and its tokens written to that queue, so a token is offered after the item that
// closes it has been scanned and written. One item is taken every cycle while the queue
// keeps two slots free; an item that gives two tokens (a flushed identifier, integer or
// minus followed by another token, or by Eof) takes one more slot, which the result
// queue of RSP_DEPTH entries absorbs; input stalls only when fewer than two queue slots
// are free. RSP_DEPTH must be a power of two, at least two. Positions saturate at
// 2^POSITION_BITS - 1, output fields at 65535. End of source resets all positions.
module source_text_tokenizer_core #(
   parameter int POSITION_BITS = stt_pkg::POSITION_BITS,
   parameter int RSP_DEPTH     = stt_pkg::RSP_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_char_byte,
   input  logic                            req_end_of_source,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [3:0]                      rsp_token_kind,
   output logic [stt_pkg::FIELD_BITS-1:0]  rsp_start_offset,
   output logic [stt_pkg::FIELD_BITS-1:0]  rsp_token_length,
   output logic [stt_pkg::FIELD_BITS-1:0]  rsp_start_line,
   output logic [stt_pkg::FIELD_BITS-1:0]  rsp_start_column,
   output logic                            rsp_last_of_run
);

   stt_pkg::token_push_type push;
   stt_pkg::token_type      rsp_token;
   logic                    room;

   stt_scan #(
      .POSITION_BITS(POSITION_BITS)
   ) u_scan (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_byte     (req_char_byte),
      .req_end_of_source (req_end_of_source),
      .room              (room),
      .push              (push)
   );

   stt_rsp_fifo #(
      .DEPTH(RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_token (rsp_token)
   );

   assign rsp_token_kind   = rsp_token.kind;
   assign rsp_start_offset = rsp_token.start_offset;
   assign rsp_token_length = rsp_token.token_length;
   assign rsp_start_line   = rsp_token.start_line;
   assign rsp_start_column = rsp_token.start_column;
   assign rsp_last_of_run  = rsp_token.last_of_run;

endmodule
